FILE: sv/l3d_pkg.sv
// Shared constants, types and payload structs of the 3D LUT color mapper.
package l3d_pkg;

    localparam int GRID_MAX    = 33;
    localparam int STORE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(GRID_MAX);
    localparam int NN_W        = $clog2(GRID_MAX * GRID_MAX);
    localparam int CH_W        = 16;
    localparam int P_W         = CH_W + IDX_W;
    localparam int ENTRY_W     = 3 * CH_W;
    localparam int GRID_MIN    = 2;
    localparam int GRID_RESET  = 33;

    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CH_W-1:0]   chan_t;

    // Request data that does not take part in the corner arithmetic.
    typedef struct packed {
        logic            is_load;
        logic [CH_W-1:0] idx;
        chan_t [2:0]     data;
        chan_t           alpha;
    } side_t;

    // Corner k is {b, g, r} of the upper/lower choice on each axis.
    typedef struct packed {
        logic        is_load;
        logic [CH_W-1:0] load_idx;
        chan_t [2:0] load_data;
        addr_t [7:0] corner;
        chan_t [2:0] frac;
        chan_t       alpha;
    } fetch_req_t;

    typedef struct packed {
        chan_t [7:0][2:0] corner_data;
        chan_t [2:0]      frac;
        chan_t            alpha;
    } interp_req_t;

endpackage

FILE: sv/l3d_ram.sv
// Generic single-write, dual-read memory with registered read data.
module l3d_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [WIDTH-1:0]  rdata0,
    output logic [WIDTH-1:0]  rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

FILE: sv/l3d_split.sv
// Axis split and corner address generation: five register stages.
module l3d_split (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  l3d_pkg::chan_t [2:0]        chan,
    input  l3d_pkg::side_t              side,
    input  logic [l3d_pkg::IDX_W:0]     grid_n,
    input  logic [l3d_pkg::NN_W-1:0]    grid_nn,
    output logic                        out_valid,
    input  logic                        out_ready,
    output l3d_pkg::fetch_req_t         out_req
);

    localparam int NS = 5;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    l3d_pkg::side_t s_reg [NS];

    l3d_pkg::chan_t [2:0]                   a_chan_reg;
    logic [2:0][l3d_pkg::P_W-1:0]           b_p_reg;
    logic [2:0][l3d_pkg::IDX_W-1:0]         c_lo_reg;
    logic [2:0][l3d_pkg::IDX_W-1:0]         c_hi_reg;
    l3d_pkg::chan_t [2:0]                   c_f_reg;
    l3d_pkg::chan_t [2:0]                   d_f_reg;
    l3d_pkg::chan_t [2:0]                   e_f_reg;
    l3d_pkg::addr_t [1:0]                   d_bnn_reg;
    l3d_pkg::addr_t [1:0]                   d_gn_reg;
    l3d_pkg::addr_t [1:0]                   d_r_reg;
    l3d_pkg::addr_t [7:0]                   e_corner_reg;

    logic [2:0][l3d_pkg::P_W-1:0]           b_p_next;
    logic [2:0][l3d_pkg::IDX_W-1:0]         c_lo_next;
    logic [2:0][l3d_pkg::IDX_W-1:0]         c_hi_next;
    l3d_pkg::chan_t [2:0]                   c_f_next;
    l3d_pkg::addr_t [7:0]                   e_corner_next;
    l3d_pkg::side_t                         a_side_next;

    logic [l3d_pkg::IDX_W-1:0] nm1;
    assign nm1 = l3d_pkg::IDX_W'(grid_n - 1'b1);

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        a_side_next = side;
        a_side_next.is_load = req_type;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // p = c * (n - 1); dividing by 65535 is a fold of the top bits into the bottom ones.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            b_p_next[c] = l3d_pkg::P_W'(a_chan_reg[c]) * l3d_pkg::P_W'(nm1);
        end
    end

    always_comb
    begin
        logic [l3d_pkg::IDX_W-1:0] q;
        logic [l3d_pkg::CH_W:0]    s;
        for (int c = 0; c < 3; c++)
        begin
            q = b_p_reg[c][l3d_pkg::P_W-1:l3d_pkg::CH_W];
            s = {1'b0, b_p_reg[c][l3d_pkg::CH_W-1:0]} + (l3d_pkg::CH_W+1)'(q);
            if (s >= {1'b0, l3d_pkg::CH_MAX})
            begin
                c_lo_next[c] = q + 1'b1;
                c_f_next[c]  = l3d_pkg::CH_W'(s - {1'b0, l3d_pkg::CH_MAX});
            end
            else
            begin
                c_lo_next[c] = q;
                c_f_next[c]  = s[l3d_pkg::CH_W-1:0];
            end
            if ({1'b0, c_lo_next[c]} + 1'b1 < grid_n)
            begin
                c_hi_next[c] = c_lo_next[c] + 1'b1;
            end
            else
            begin
                c_hi_next[c] = nm1;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            e_corner_next[k] = d_bnn_reg[k/4] + d_gn_reg[(k/2)%2] + d_r_reg[k%2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_chan_reg <= chan;
            s_reg[0]   <= a_side_next;
        end
        if (en[1])
        begin
            b_p_reg  <= b_p_next;
            s_reg[1] <= s_reg[0];
        end
        if (en[2])
        begin
            c_lo_reg <= c_lo_next;
            c_hi_reg <= c_hi_next;
            c_f_reg  <= c_f_next;
            s_reg[2] <= s_reg[1];
        end
        if (en[3])
        begin
            d_bnn_reg[0] <= l3d_pkg::ADDR_W'(c_lo_reg[2]) * l3d_pkg::ADDR_W'(grid_nn);
            d_bnn_reg[1] <= l3d_pkg::ADDR_W'(c_hi_reg[2]) * l3d_pkg::ADDR_W'(grid_nn);
            d_gn_reg[0]  <= l3d_pkg::ADDR_W'(c_lo_reg[1]) * l3d_pkg::ADDR_W'(grid_n);
            d_gn_reg[1]  <= l3d_pkg::ADDR_W'(c_hi_reg[1]) * l3d_pkg::ADDR_W'(grid_n);
            d_r_reg[0]   <= l3d_pkg::ADDR_W'(c_lo_reg[0]);
            d_r_reg[1]   <= l3d_pkg::ADDR_W'(c_hi_reg[0]);
            d_f_reg      <= c_f_reg;
            s_reg[3]     <= s_reg[2];
        end
        if (en[4])
        begin
            e_corner_reg <= e_corner_next;
            e_f_reg      <= d_f_reg;
            s_reg[4]     <= s_reg[3];
        end
    end

    assign out_valid         = v_reg[NS-1];
    assign out_req.is_load   = s_reg[NS-1].is_load;
    assign out_req.load_idx  = s_reg[NS-1].idx;
    assign out_req.load_data = s_reg[NS-1].data;
    assign out_req.corner    = e_corner_reg;
    assign out_req.frac      = e_f_reg;
    assign out_req.alpha     = s_reg[NS-1].alpha;

endmodule

FILE: sv/l3d_fetch.sv
// Table store in four copies, each read at two corners; loads write all copies.
module l3d_fetch (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  l3d_pkg::fetch_req_t   in_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output l3d_pkg::interp_req_t  out_req
);

    logic v_reg;
    logic en;
    logic we;
    logic re;
    logic [l3d_pkg::ENTRY_W-1:0] rdata [8];
    l3d_pkg::chan_t [2:0] frac_reg;
    l3d_pkg::chan_t       alpha_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;
    assign re       = in_valid && en && !in_req.is_load;
    // Loads are ordered with pixels here, so a later pixel sees the entry.
    assign we       = in_valid && en && in_req.is_load
                      && (in_req.load_idx < l3d_pkg::CH_W'(l3d_pkg::STORE_DEPTH));

    for (genvar i = 0; i < 4; i++)
    begin : g_copy
        l3d_ram #(
            .DEPTH  (l3d_pkg::STORE_DEPTH),
            .WIDTH  (l3d_pkg::ENTRY_W),
            .ADDR_W (l3d_pkg::ADDR_W)
        ) u_ram (
            .clk    (clk),
            .we     (we),
            .waddr  (l3d_pkg::ADDR_W'(in_req.load_idx)),
            .wdata  (in_req.load_data),
            .re     (re),
            .raddr0 (in_req.corner[2*i]),
            .raddr1 (in_req.corner[2*i+1]),
            .rdata0 (rdata[2*i]),
            .rdata1 (rdata[2*i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid && !in_req.is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_reg  <= in_req.frac;
            alpha_reg <= in_req.alpha;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            out_req.corner_data[k] = rdata[k];
        end
    end

    assign out_req.frac  = frac_reg;
    assign out_req.alpha = alpha_reg;
    assign out_valid     = v_reg;

endmodule

FILE: sv/l3d_interp.sv
// Trilinear blend, rounding and clamping: six register stages.
module l3d_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  l3d_pkg::interp_req_t  in_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output l3d_pkg::chan_t [2:0]  out_rgb,
    output l3d_pkg::chan_t        out_alpha
);

    localparam int NS = 6;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    l3d_pkg::chan_t alpha_reg [NS];
    l3d_pkg::chan_t fg_reg [1];
    l3d_pkg::chan_t fb_reg [3];

    logic [2:0][3:0][31:0]         x_reg;
    logic [2:0][3:0][31:0]         x_next;
    logic signed [49:0]            ym_reg [3][2];
    logic [31:0]                   yb_reg [3][2];
    logic [47:0]                   y_reg  [3][2];
    logic [23:0]                   zlo_sel;
    logic [39:0]                   zlo_reg [3];
    logic signed [41:0]            zhi_reg [3];
    logic [47:0]                   zb_reg  [3];
    logic [63:0]                   z_reg   [3];
    l3d_pkg::chan_t [2:0]          v_out_reg;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Lerp along red: lo*65536 + (hi - lo)*f, which equals lo*(65536-f) + hi*f.
    always_comb
    begin
        logic signed [16:0] d;
        logic signed [33:0] t;
        for (int c = 0; c < 3; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                d = $signed({1'b0, in_req.corner_data[2*j+1][c]})
                    - $signed({1'b0, in_req.corner_data[2*j][c]});
                t = $signed({2'b00, in_req.corner_data[2*j][c], 16'h0000})
                    + 34'(d * $signed({1'b0, in_req.frac[0]}));
                x_next[c][j] = t[31:0];
            end
        end
    end

    assign zlo_sel = '0;

    always_ff @(posedge clk)
    begin
        logic signed [32:0] dx;
        logic signed [49:0] ty;
        logic signed [48:0] dy;
        logic signed [65:0] tz;
        if (en[0])
        begin
            x_reg        <= x_next;
            fg_reg[0]    <= in_req.frac[1];
            fb_reg[0]    <= in_req.frac[2];
            alpha_reg[0] <= in_req.alpha;
        end
        if (en[1])
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int m = 0; m < 2; m++)
                begin
                    dx = $signed({1'b0, x_reg[c][2*m+1]}) - $signed({1'b0, x_reg[c][2*m]});
                    ym_reg[c][m] <= 50'(dx * $signed({1'b0, fg_reg[0]}));
                    yb_reg[c][m] <= x_reg[c][2*m];
                end
            end
            fb_reg[1]    <= fb_reg[0];
            alpha_reg[1] <= alpha_reg[0];
        end
        if (en[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int m = 0; m < 2; m++)
                begin
                    ty = $signed({2'b00, yb_reg[c][m], 16'h0000}) + ym_reg[c][m];
                    y_reg[c][m] <= ty[47:0];
                end
            end
            fb_reg[2]    <= fb_reg[1];
            alpha_reg[2] <= alpha_reg[1];
        end
        if (en[3])
        begin
            // The blue step is cut into two partial products of the difference.
            for (int c = 0; c < 3; c++)
            begin
                dy = $signed({1'b0, y_reg[c][1]}) - $signed({1'b0, y_reg[c][0]});
                zlo_reg[c] <= (dy[23:0] | zlo_sel) * 40'(fb_reg[2]);
                zhi_reg[c] <= 42'($signed(dy[48:24]) * $signed({1'b0, fb_reg[2]}));
                zb_reg[c]  <= y_reg[c][0];
            end
            alpha_reg[3] <= alpha_reg[2];
        end
        if (en[4])
        begin
            for (int c = 0; c < 3; c++)
            begin
                tz = $signed({2'b00, zb_reg[c], 16'h0000})
                     + ($signed(66'(zhi_reg[c])) <<< 24)
                     + $signed({26'd0, zlo_reg[c]});
                z_reg[c] <= tz[63:0];
            end
            alpha_reg[4] <= alpha_reg[3];
        end
        if (en[5])
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (({1'b0, z_reg[c][63:47]} + 18'd1) >> 1 > 18'(l3d_pkg::CH_MAX))
                begin
                    v_out_reg[c] <= l3d_pkg::CH_MAX;
                end
                else
                begin
                    v_out_reg[c] <= l3d_pkg::CH_W'(({1'b0, z_reg[c][63:47]} + 18'd1) >> 1);
                end
            end
            alpha_reg[5] <= alpha_reg[4];
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_rgb   = v_out_reg;
    assign out_alpha = alpha_reg[NS-1];

endmodule

FILE: sv/lut3d_trilinear_color_map_unit.sv
// Top level of the 3D LUT color mapper with trilinear interpolation.
// The block takes one request per clock while in_stall is low, pixel or table load,
// and delivers a mapped pixel after the split, fetch and interpolation stages; a stall
// holds the pipeline stage by stage, so bubbles close up and nothing is lost.
// Loads travel down the same pipeline and write the table at the fetch stage, so
// every pixel sees exactly the loads that came before it. The table is kept in four
// copies with two read ports each, which delivers all eight cube corners together.
// Entries are undefined until loaded and there is no clearing pass after reset.
// grid_size may only be written while the block is idle; values below 2 act as 2
// and values above 33 act as 33.
module lut3d_trilinear_color_map_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  grid_size,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    input  logic [15:0] alpha,
    input  logic [15:0] entry_index,
    input  logic [15:0] entry_red,
    input  logic [15:0] entry_green,
    input  logic [15:0] entry_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_red,
    output logic [15:0] out_green,
    output logic [15:0] out_blue,
    output logic [15:0] out_alpha
);

    logic [l3d_pkg::IDX_W:0]   grid_n_reg;
    logic [l3d_pkg::NN_W-1:0]  grid_nn_reg;
    logic [l3d_pkg::IDX_W:0]   grid_n_next;

    logic                  split_ready;
    logic                  split_valid;
    logic                  fetch_ready;
    logic                  fetch_valid;
    logic                  interp_ready;
    l3d_pkg::fetch_req_t   fetch_req;
    l3d_pkg::interp_req_t  interp_req;
    l3d_pkg::chan_t [2:0]  in_chan;
    l3d_pkg::side_t        in_side;
    l3d_pkg::chan_t [2:0]  rgb;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (grid_size < 6'(l3d_pkg::GRID_MIN))
        begin
            grid_n_next = (l3d_pkg::IDX_W+1)'(l3d_pkg::GRID_MIN);
        end
        else if (grid_size > 6'(l3d_pkg::GRID_MAX))
        begin
            grid_n_next = (l3d_pkg::IDX_W+1)'(l3d_pkg::GRID_MAX);
        end
        else
        begin
            grid_n_next = (l3d_pkg::IDX_W+1)'(grid_size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_n_reg  <= (l3d_pkg::IDX_W+1)'(l3d_pkg::GRID_RESET);
            grid_nn_reg <= l3d_pkg::NN_W'(l3d_pkg::GRID_RESET * l3d_pkg::GRID_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            grid_n_reg  <= grid_n_next;
            grid_nn_reg <= l3d_pkg::NN_W'(grid_n_next) * l3d_pkg::NN_W'(grid_n_next);
        end
    end

    assign in_chan[0]    = red;
    assign in_chan[1]    = green;
    assign in_chan[2]    = blue;
    assign in_side.is_load = req_type;
    assign in_side.idx   = entry_index;
    assign in_side.data  = {entry_blue, entry_green, entry_red};
    assign in_side.alpha = alpha;

    assign in_stall = !split_ready;

    l3d_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (split_ready),
        .req_type  (req_type),
        .chan      (in_chan),
        .side      (in_side),
        .grid_n    (grid_n_reg),
        .grid_nn   (grid_nn_reg),
        .out_valid (split_valid),
        .out_ready (fetch_ready),
        .out_req   (fetch_req)
    );

    l3d_fetch u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_ready  (fetch_ready),
        .in_req    (fetch_req),
        .out_valid (fetch_valid),
        .out_ready (interp_ready),
        .out_req   (interp_req)
    );

    l3d_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fetch_valid),
        .in_ready  (interp_ready),
        .in_req    (interp_req),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_rgb   (rgb),
        .out_alpha (out_alpha)
    );

    assign out_red   = rgb[0];
    assign out_green = rgb[1];
    assign out_blue  = rgb[2];

    // The input only stalls when every stage down to the output is full and blocked.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the pipeline has room");

    a_grid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (grid_n_reg >= (l3d_pkg::IDX_W+1)'(l3d_pkg::GRID_MIN))
        && (grid_n_reg <= (l3d_pkg::IDX_W+1)'(l3d_pkg::GRID_MAX)))
        else $error("grid size in use is out of range");

    a_grid_square: assert property (@(posedge clk) disable iff (!rst_n)
        grid_nn_reg == l3d_pkg::NN_W'(grid_n_reg) * l3d_pkg::NN_W'(grid_n_reg))
        else $error("grid plane size does not match grid size");

endmodule

FILE: sim/tb_lut3d_trilinear_color_map_unit.sv
// Self-checking testbench for the 3D LUT trilinear color mapper.
module tb_lut3d_trilinear_color_map_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 30;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
    } pixel_t;

    typedef struct {
        bit          is_load;
        logic [15:0] r, g, b, a;
        logic [15:0] idx, er, eg, eb;
        bit          typed;
        pixel_t      want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  grid_size = 6'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [15:0] red = '0, green = '0, blue = '0, alpha = '0;
    logic [15:0] entry_index = '0, entry_red = '0, entry_green = '0, entry_blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_red, out_green, out_blue, out_alpha;

    lut3d_trilinear_color_map_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .grid_size(grid_size),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .entry_index(entry_index), .entry_red(entry_red),
        .entry_green(entry_green), .entry_blue(entry_blue),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Model copy of the table and the grid register.
    logic [15:0] lut_copy [l3d_pkg::STORE_DEPTH][3];
    logic [5:0]  grid_reg = 6'(l3d_pkg::GRID_RESET);
    pixel_t      mapped_q [$];

    int errors = 0;
    int n_pixels = 0;
    int n_loads = 0;
    int n_results = 0;
    int idle_cycles = 0;
    bit burst_mode = 1'b0;

    function automatic int grid_eff();
        int n;
        n = grid_reg;
        if (n < l3d_pkg::GRID_MIN) n = l3d_pkg::GRID_MIN;
        if (n > l3d_pkg::GRID_MAX) n = l3d_pkg::GRID_MAX;
        return n;
    endfunction

    function automatic longint unsigned lerp16(longint unsigned lo, longint unsigned hi,
                                               longint unsigned f);
        return lo * (64'd65536 - f) + hi * f;
    endfunction

    function automatic pixel_t map_pixel(logic [15:0] cr, logic [15:0] cg, logic [15:0] cb,
                                         logic [15:0] ca);
        int n, k, ch;
        logic [15:0] c [3];
        int lo [3], hi [3];
        longint unsigned f [3];
        longint unsigned p, rem, v;
        longint unsigned x [4];
        longint unsigned y0, y1, z;
        logic [15:0] res [3];
        pixel_t o;
        n = grid_eff();
        c[0] = cr; c[1] = cg; c[2] = cb;
        for (k = 0; k < 3; k++)
        begin
            p = longint'(c[k]) * (n - 1);
            lo[k] = int'(p / 65535);
            rem = p % 65535;
            if (lo[k] > n - 1) lo[k] = n - 1;
            hi[k] = (lo[k] + 1 < n) ? lo[k] + 1 : n - 1;
            f[k] = (rem * 65536) / 65535;
        end
        for (ch = 0; ch < 3; ch++)
        begin
            for (k = 0; k < 4; k++)
            begin
                // k bit 0 selects the green corner, bit 1 the blue corner.
                x[k] = lerp16(
                    lut_copy[(k[1] ? hi[2] : lo[2]) * n * n + (k[0] ? hi[1] : lo[1]) * n
                             + lo[0]][ch],
                    lut_copy[(k[1] ? hi[2] : lo[2]) * n * n + (k[0] ? hi[1] : lo[1]) * n
                             + hi[0]][ch],
                    f[0]);
            end
            y0 = lerp16(x[0], x[1], f[1]);
            y1 = lerp16(x[2], x[3], f[1]);
            z = lerp16(y0, y1, f[2]);
            v = ((z >> 47) + 1) >> 1;
            if (v > 65535) v = 65535;
            res[ch] = v[15:0];
        end
        o.r = res[0]; o.g = res[1]; o.b = res[2]; o.a = ca;
        return o;
    endfunction

    function automatic int pick_gap();
        int sel;
        if (burst_mode) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Presents one request after an optional random idle gap, waits for acceptance, then updates the model.
    task automatic send(stim_row_t row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type <= row.is_load;
        red <= row.r; green <= row.g; blue <= row.b; alpha <= row.a;
        entry_index <= row.idx;
        entry_red <= row.er; entry_green <= row.eg; entry_blue <= row.eb;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (row.is_load)
        begin
            n_loads++;
            if (row.idx < l3d_pkg::STORE_DEPTH)
            begin
                lut_copy[row.idx][0] = row.er;
                lut_copy[row.idx][1] = row.eg;
                lut_copy[row.idx][2] = row.eb;
            end
        end
        else
        begin
            n_pixels++;
            mapped_q.push_back(row.typed ? row.want : map_pixel(row.r, row.g, row.b, row.a));
        end
    endtask

    task automatic finish_stream();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_grid(logic [5:0] value);
        wait (mapped_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        grid_size <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        grid_reg = value;
    endtask

    function automatic stim_row_t load_row(int idx);
        stim_row_t row;
        row = '{default: '0};
        row.is_load = 1'b1;
        row.r = $urandom; row.g = $urandom; row.b = $urandom; row.a = $urandom;
        row.idx = idx[15:0];
        row.er = $urandom; row.eg = $urandom; row.eb = $urandom;
        return row;
    endfunction

    // Grid points loaded on one axis: all of them on a small grid, else the two at each end.
    function automatic int axis_pt(int n, int j);
        if (n <= 4) return j;
        return (j < 2) ? j : n - 4 + j;
    endfunction

    task automatic load_corners();
        int n, m, ib, ig, ir;
        n = grid_eff();
        m = (n < 4) ? n : 4;
        for (ib = 0; ib < m; ib++)
        begin
            for (ig = 0; ig < m; ig++)
            begin
                for (ir = 0; ir < m; ir++)
                begin
                    send(load_row(axis_pt(n, ib) * n * n + axis_pt(n, ig) * n
                                  + axis_pt(n, ir)));
                end
            end
        end
    endtask

    function automatic logic [15:0] pick_chan();
        int sel, n, k, low_top, high_base;
        logic [15:0] v;
        sel = $urandom_range(0, 9);
        n = grid_eff();
        k = $urandom_range(0, n - 1);
        low_top = 65534 / (n - 1);
        high_base = ((n - 2) * 65535 + n - 2) / (n - 1);
        if (n <= 4)
        begin
            case (sel)
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                2: v = 16'((k * 65535) / (n - 1) + $urandom_range(0, 2) - 1);
                default: v = $urandom;
            endcase
        end
        else
        begin
            // Only the end cells of each axis have all their corners loaded.
            case (sel)
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                2: v = 16'(low_top - $urandom_range(0, 1));
                3: v = 16'(high_base + $urandom_range(0, 1));
                4, 5, 6: v = 16'($urandom_range(0, low_top));
                default: v = 16'($urandom_range(high_base, 65535));
            endcase
        end
        return v;
    endfunction

    function automatic stim_row_t pixel_row();
        stim_row_t row;
        row = '{default: '0};
        row.r = pick_chan(); row.g = pick_chan(); row.b = pick_chan(); row.a = $urandom;
        row.idx = $urandom; row.er = $urandom; row.eg = $urandom; row.eb = $urandom;
        return row;
    endfunction

    task automatic random_items(int count);
        int i, n, sel;
        n = grid_eff();
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
            sel = $urandom_range(0, 99);
            if (sel < 85) send(pixel_row());
            else if (sel < 95) send(load_row($urandom_range(0, n * n * n - 1)));
            else send(load_row($urandom_range(0, 65535)));
        end
        finish_stream();
    endtask

    task automatic grid_phase(logic [5:0] value, bit preload, int count);
        write_grid(value);
        if (preload) load_corners();
        random_items(count);
    endtask

    stim_row_t directed [] = '{
        '{1, 0, 0, 0, 0, 16'd35936, 16'd1, 16'd2, 16'd3, 0, '0},
        '{0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 1,
          '{16'd1, 16'd2, 16'd3, 16'hFFFF}},
        '{1, 0, 0, 0, 0, 16'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 0, '0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}},
        '{1, 0, 0, 0, 0, 16'hFFFF, 16'h1111, 16'h2222, 16'h3333, 0, '0},
        '{1, 0, 0, 0, 0, 16'd35937, 16'h4444, 16'h5555, 16'h6666, 0, '0},
        '{0, 0, 0, 0, 16'h1234, 0, 0, 0, 0, 1, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234}},
        '{1, 0, 0, 0, 0, 16'd32, 16'h8000, 16'h8000, 16'h8000, 0, '0},
        '{0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 1, '{16'h8000, 16'h8000, 16'h8000, 16'h0000}},
        '{1, 0, 0, 0, 0, 16'd1, 16'h0000, 16'hFFFF, 16'h0000, 0, '0},
        '{0, 16'd2047, 0, 0, 16'h00FF, 0, 0, 0, 0, 0, '0},
        '{0, 16'd1024, 16'd63488, 16'd1, 16'hFF00, 0, 0, 0, 0, 0, '0},
        '{0, 16'hFFFE, 16'h0001, 16'hFFFF, 16'h8000, 0, 0, 0, 0, 0, '0},
        '{0, 16'hF800, 16'h0555, 16'h07FF, 16'h5555, 0, 0, 0, 0, 0, '0},
        '{0, 16'd1, 16'd65534, 16'd2047, 16'hAAAA, 0, 0, 0, 0, 0, '0}
    };

    // Output back-pressure with random stalls, and stall-free stretches in burst mode.
    always @(posedge clk)
    begin
        int sel;
        sel = $urandom_range(0, 99);
        if (burst_mode || sel < 65) out_stall <= 1'b0;
        else if (sel < 97) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (mapped_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel %h %h %h %h", $time,
                         out_red, out_green, out_blue, out_alpha);
            end
            else
            begin
                want = mapped_q.pop_front();
                if (out_red !== want.r)
                begin
                    errors++;
                    $display("%0t: out_red expected %h actual %h", $time, want.r, out_red);
                end
                if (out_green !== want.g)
                begin
                    errors++;
                    $display("%0t: out_green expected %h actual %h", $time, want.g, out_green);
                end
                if (out_blue !== want.b)
                begin
                    errors++;
                    $display("%0t: out_blue expected %h actual %h", $time, want.b, out_blue);
                end
                if (out_alpha !== want.a)
                begin
                    errors++;
                    $display("%0t: out_alpha expected %h actual %h", $time, want.a, out_alpha);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL lut3d_trilinear_color_map_unit");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every corner that a pixel can reach is loaded before any pixel is sent.
        load_corners();
        foreach (directed[j]) send(directed[j]);
        random_items(120);

        grid_phase(6'd2, 1'b1, 50);
        grid_phase(6'd0, 1'b0, 20);
        grid_phase(6'd1, 1'b0, 20);
        grid_phase(6'd3, 1'b1, 40);
        grid_phase(6'd17, 1'b1, 30);
        grid_phase(6'd63, 1'b0, 30);

        wait (mapped_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d pixel requests and %0d load requests, %0d results checked,",
                 n_pixels, n_loads, n_results);
        $display("over grid settings 33, 2, 0, 1, 3, 17 and 63; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("PASS lut3d_trilinear_color_map_unit");
        else
            $display("FAIL lut3d_trilinear_color_map_unit");
        $finish;
    end

endmodule

FILE: filelist.f
sv/l3d_pkg.sv
sv/l3d_ram.sv
sv/l3d_split.sv
sv/l3d_fetch.sv
sv/l3d_interp.sv
sv/lut3d_trilinear_color_map_unit.sv
sim/tb_lut3d_trilinear_color_map_unit.sv
